@@ sv/pffs_pkg.sv @@
`default_nettype none

package pffs_pkg;

   localparam int MAX_PAGES   = 4096;
   localparam int PAGE_W      = $clog2(MAX_PAGES);
   localparam int COUNT_W     = $clog2(MAX_PAGES + 1);
   localparam int CSR_INDEX_W = 1;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_NOT_USED = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_PAGES    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_PAGES = CSR_INDEX_W'(1);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAGES);
   localparam logic [PAGE_W-1:0]  LAST_IDX  = PAGE_W'(MAX_PAGES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_INIT,
      S_ALLOC,
      S_FREE,
      S_REPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic sweep_step;
      logic sweep_init;
      logic alloc_fire;
      logic free_fire;
      logic plain_fire;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic sweep_last;
   } stat_type;

endpackage

`default_nettype wire

@@ sv/pffs_ctrl.sv @@
`default_nettype none

module pffs_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [1:0]      req_operation,
   input  wire pffs_pkg::stat_type stat,
   output logic                 req_stall,
   output pffs_pkg::cmd_type    cmd
);

   pffs_pkg::state_type state_ff;
   pffs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pffs_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         pffs_pkg::S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = pffs_pkg::S_IDLE;
            end
         end
         pffs_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_operation)
                  pffs_pkg::OP_INIT:  state_in = pffs_pkg::S_INIT;
                  pffs_pkg::OP_ALLOC: state_in = pffs_pkg::S_ALLOC;
                  pffs_pkg::OP_FREE:  state_in = pffs_pkg::S_FREE;
                  default:            state_in = pffs_pkg::S_REPLY;
               endcase
            end
         end
         pffs_pkg::S_INIT: begin
            cmd.sweep_step = 1'b1;
            cmd.sweep_init = 1'b1;
            if (stat.sweep_last) begin
               state_in = pffs_pkg::S_REPLY;
            end
         end
         pffs_pkg::S_ALLOC: begin
            if (stat.out_free) begin
               cmd.alloc_fire = 1'b1;
               state_in       = pffs_pkg::S_IDLE;
            end
         end
         pffs_pkg::S_FREE: begin
            if (stat.out_free) begin
               cmd.free_fire = 1'b1;
               state_in      = pffs_pkg::S_IDLE;
            end
         end
         pffs_pkg::S_REPLY: begin
            if (stat.out_free) begin
               cmd.plain_fire = 1'b1;
               state_in       = pffs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pffs_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/pffs_dp.sv @@
`default_nettype none

module pffs_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pffs_pkg::cmd_type                   cmd,
   output pffs_pkg::stat_type                       stat,
   input  wire logic [pffs_pkg::PAGE_W-1:0]         req_page,
   input  wire logic                                csr_valid,
   input  wire logic [pffs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [pffs_pkg::COUNT_W-1:0]        csr_wdata,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pffs_pkg::PAGE_W-1:0]              rsp_frame,
   output logic [1:0]                               rsp_status,
   output logic [pffs_pkg::COUNT_W-1:0]             rsp_free_count
);

   // Configuration registers.
   logic [pffs_pkg::COUNT_W-1:0] total_ff;
   logic [pffs_pkg::COUNT_W-1:0] reserved_ff;

   // Stack pointer, sweep index and captured request.
   logic [pffs_pkg::COUNT_W-1:0] depth_ff;
   logic [pffs_pkg::COUNT_W-1:0] depth_in;
   logic [pffs_pkg::PAGE_W-1:0]  idx_ff;
   logic [pffs_pkg::PAGE_W-1:0]  idx_in;
   logic [pffs_pkg::PAGE_W-1:0]  page_ff;
   logic [pffs_pkg::PAGE_W-1:0]  page_in;

   // Memories and their registered read data.
   logic [pffs_pkg::PAGE_W-1:0] stack_mem [pffs_pkg::MAX_PAGES];
   logic                        map_mem   [pffs_pkg::MAX_PAGES];
   logic [pffs_pkg::PAGE_W-1:0] stack_rd_ff;
   logic                        map_rd_ff;

   logic                        stack_we;
   logic [pffs_pkg::PAGE_W-1:0] stack_waddr;
   logic [pffs_pkg::PAGE_W-1:0] stack_wdata;
   logic [pffs_pkg::PAGE_W-1:0] stack_raddr;
   logic                        map_we;
   logic [pffs_pkg::PAGE_W-1:0] map_waddr;
   logic                        map_wdata;
   logic [pffs_pkg::PAGE_W-1:0] map_raddr;

   // Result register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [pffs_pkg::PAGE_W-1:0]  rsp_frame_ff;
   logic [pffs_pkg::PAGE_W-1:0]  rsp_frame_in;
   logic [1:0]                   rsp_status_ff;
   logic [1:0]                   rsp_status_in;
   logic [pffs_pkg::COUNT_W-1:0] rsp_count_ff;

   logic [pffs_pkg::COUNT_W-1:0] total_eff;
   logic [pffs_pkg::COUNT_W-1:0] res_eff;
   logic [pffs_pkg::COUNT_W-1:0] idx_wide;
   logic [pffs_pkg::COUNT_W-1:0] depth_m1;
   logic [pffs_pkg::COUNT_W-1:0] sweep_frame;
   logic                         sweep_last;
   logic                         stack_empty;
   logic                         in_range;
   logic                         free_ok;
   logic                         push_room;
   logic                         load;

   always_comb begin
      total_eff   = (total_ff > pffs_pkg::MAX_COUNT) ? pffs_pkg::MAX_COUNT : total_ff;
      res_eff     = (reserved_ff > total_eff) ? total_eff : reserved_ff;
      idx_wide    = {1'b0, idx_ff};
      depth_m1    = depth_ff - pffs_pkg::COUNT_W'(1);
      sweep_frame = total_eff - pffs_pkg::COUNT_W'(1) - idx_wide;
      sweep_last  = (idx_ff == pffs_pkg::LAST_IDX);
      stack_empty = (depth_ff == '0);
      in_range    = ({1'b0, page_ff} < total_eff);
      free_ok     = in_range && map_rd_ff;
      push_room   = (depth_ff < pffs_pkg::MAX_COUNT);
      load        = cmd.alloc_fire || cmd.free_fire || cmd.plain_fire;
   end

   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;
   assign stat.sweep_last = sweep_last;

   // Next values of the control registers.
   always_comb begin
      idx_in  = idx_ff;
      page_in = cmd.capture ? req_page : page_ff;
      if (cmd.sweep_step) begin
         idx_in = sweep_last ? '0 : idx_ff + pffs_pkg::PAGE_W'(1);
      end

      depth_in = depth_ff;
      if (cmd.sweep_step && cmd.sweep_init && sweep_last) begin
         depth_in = total_eff - res_eff;
      end else if (cmd.alloc_fire && !stack_empty) begin
         depth_in = depth_m1;
      end else if (cmd.free_fire && free_ok && push_room) begin
         depth_in = depth_ff + pffs_pkg::COUNT_W'(1);
      end
   end

   // Memory port selection.
   always_comb begin
      stack_raddr = depth_m1[pffs_pkg::PAGE_W-1:0];
      map_raddr   = cmd.capture ? req_page : page_ff;

      stack_we    = 1'b0;
      stack_waddr = idx_ff;
      stack_wdata = sweep_frame[pffs_pkg::PAGE_W-1:0];
      if (cmd.sweep_step && cmd.sweep_init && (idx_wide < total_eff)) begin
         stack_we = 1'b1;
      end else if (cmd.free_fire && free_ok && push_room) begin
         stack_we    = 1'b1;
         stack_waddr = depth_ff[pffs_pkg::PAGE_W-1:0];
         stack_wdata = page_ff;
      end

      map_we    = 1'b0;
      map_waddr = idx_ff;
      map_wdata = 1'b0;
      if (cmd.sweep_step) begin
         map_we    = 1'b1;
         map_wdata = cmd.sweep_init && (idx_wide < res_eff);
      end else if (cmd.alloc_fire && !stack_empty) begin
         map_we    = 1'b1;
         map_waddr = stack_rd_ff;
         map_wdata = 1'b1;
      end else if (cmd.free_fire && free_ok) begin
         map_we    = 1'b1;
         map_waddr = page_ff;
         map_wdata = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   // Result selection.
   always_comb begin
      rsp_frame_in  = '0;
      rsp_status_in = pffs_pkg::STATUS_OK;
      if (cmd.alloc_fire) begin
         if (stack_empty) begin
            rsp_status_in = pffs_pkg::STATUS_EMPTY;
         end else begin
            rsp_frame_in = stack_rd_ff;
         end
      end else if (cmd.free_fire) begin
         if (!in_range) begin
            rsp_status_in = pffs_pkg::STATUS_RANGE;
         end else if (!map_rd_ff) begin
            rsp_status_in = pffs_pkg::STATUS_NOT_USED;
         end else begin
            rsp_frame_in = page_ff;
         end
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= pffs_pkg::MAX_COUNT;
         reserved_ff  <= '0;
         depth_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               pffs_pkg::CSR_TOTAL_PAGES:    total_ff    <= csr_wdata;
               pffs_pkg::CSR_RESERVED_PAGES: reserved_ff <= csr_wdata;
               default: ;
            endcase
         end
         depth_ff     <= depth_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      if (load) begin
         rsp_frame_ff  <= rsp_frame_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= depth_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame      = rsp_frame_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_count = rsp_count_ff;

endmodule

`default_nettype wire

@@ sv/page_frame_free_stack_unit.sv @@
// Physical page-frame allocator built around a LIFO stack of free frame
// numbers and a one-bit in-use map, both held in single-port-write RAMs.
// Requests arrive on the req_ channel (operation, page) and every request
// produces exactly one transfer on the rsp_ channel (frame, status,
// free_count). The csr_ channel writes total_pages (index 0) and
// reserved_pages (index 1); it is always ready and should only be used
// while no request is outstanding.
// Allocate and free first capture the request and issue its stack or
// map read; then, once the output register is free, the result is
// loaded into the output register and the RAMs are updated. An unknown
// operation is captured and then answered without touching the RAMs.
// Init sweeps the whole RAM depth, one frame per cycle. After reset
// the block runs the same sweep to clear the in-use map, holding
// req_stall high until it ends; the stack starts empty. The output
// register decouples the two sides, so a new request is taken while a
// result is still waiting; when rsp_stall is held, the next request
// stops at its result cycle until the output register is free.

`default_nettype none

module page_frame_free_stack_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_operation,
   input  wire logic [pffs_pkg::PAGE_W-1:0]      req_page,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [pffs_pkg::PAGE_W-1:0]           rsp_frame,
   output logic [1:0]                            rsp_status,
   output logic [pffs_pkg::COUNT_W-1:0]          rsp_free_count,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pffs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pffs_pkg::COUNT_W-1:0]     csr_wdata
);

   pffs_pkg::cmd_type  cmd;
   pffs_pkg::stat_type stat;

   // Register writes go straight into the registers, so the port never pushes back.
   assign csr_ready = 1'b1;

   // The controller sequences each request; it sees only the request valid,
   // the operation code and the datapath status.
   pffs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .stat          (stat),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   // The datapath holds the RAMs, the stack pointer, the sweep index and
   // the output register.
   pffs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_page       (req_page),
      .csr_valid      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame      (rsp_frame),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count)
   );

   // The clearing pass must block requests right after reset.
   assert property (@(posedge clock) $past(reset) && !reset |-> req_stall)
      else $error("request port open right after reset");

   // At most one datapath action is commanded in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.sweep_step, cmd.alloc_fire, cmd.free_fire,
                cmd.plain_fire}))
      else $error("conflicting datapath commands");

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_fire || cmd.free_fire || cmd.plain_fire) |-> stat.out_free)
      else $error("result loaded over a pending transfer");

   // The free count can never exceed MAX_PAGES, the RAM depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_count <= pffs_pkg::MAX_COUNT))
      else $error("free count beyond frame count");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // The block has no name for operation code 3; it must leave all state
   // alone and answer with frame 0, status ok and the current free count.
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   typedef struct packed {
      logic [1:0]                  op;
      logic [pffs_pkg::PAGE_W-1:0] page;
   } page_request_type;

   typedef struct packed {
      logic [pffs_pkg::PAGE_W-1:0]  frame;
      logic [1:0]                   status;
      logic [pffs_pkg::COUNT_W-1:0] free_count;
   } frame_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_operation = pffs_pkg::OP_INIT;
   logic [pffs_pkg::PAGE_W-1:0]      req_page = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [pffs_pkg::PAGE_W-1:0]      rsp_frame;
   logic [1:0]                       rsp_status;
   logic [pffs_pkg::COUNT_W-1:0]     rsp_free_count;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [pffs_pkg::CSR_INDEX_W-1:0] csr_index = pffs_pkg::CSR_TOTAL_PAGES;
   logic [pffs_pkg::COUNT_W-1:0]     csr_wdata = '0;

   page_frame_free_stack_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_page       (req_page),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame      (rsp_frame),
      .rsp_status     (rsp_status),
      .rsp_free_count (rsp_free_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Requests waiting to be driven, and the responses that the shadow
   // allocator says must come back, oldest first.
   page_request_type page_requests[$];
   frame_result_type due_results[$];

   // Shadow copy of the allocator: registers, free stack and in-use map.
   logic [pffs_pkg::COUNT_W-1:0] shadow_total = pffs_pkg::COUNT_W'(pffs_pkg::MAX_PAGES);
   logic [pffs_pkg::COUNT_W-1:0] shadow_reserved = '0;
   logic [pffs_pkg::PAGE_W-1:0]  shadow_stack [pffs_pkg::MAX_PAGES];
   int unsigned                  shadow_depth = 0;
   bit                           shadow_in_use [pffs_pkg::MAX_PAGES];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned requests_made = 0;
   int unsigned mismatches = 0;

   page_request_type next_request;
   frame_result_type oldest_due;

   // Number of frames the allocator treats as present. A register value
   // above the RAM depth is clamped to the depth.
   function automatic int unsigned frames_present();
      return (shadow_total > pffs_pkg::COUNT_W'(pffs_pkg::MAX_PAGES)) ?
             pffs_pkg::MAX_PAGES : int'(shadow_total);
   endfunction

   // Apply one accepted request to the shadow allocator and queue the
   // response it must produce.
   task automatic allocator_step(input logic [1:0] op,
                                 input logic [pffs_pkg::PAGE_W-1:0] page);
      frame_result_type res;
      int unsigned      present;
      int unsigned      held;
      int unsigned      i;
      res = '0;
      res.status = pffs_pkg::STATUS_OK;
      present = frames_present();
      case (op)
         pffs_pkg::OP_INIT: begin
            // Rebuild so that frame 0 sits on top, then hand the first
            // reserved frames to the system. Reserved saturates at the total.
            held = (int'(shadow_reserved) > present) ? present : int'(shadow_reserved);
            for (i = 0; i < pffs_pkg::MAX_PAGES; i++) begin
               shadow_in_use[pffs_pkg::PAGE_W'(i)] = 1'b0;
            end
            for (i = 0; i < present; i++) begin
               shadow_stack[pffs_pkg::PAGE_W'(i)] = pffs_pkg::PAGE_W'(present - 1 - i);
            end
            for (i = 0; i < held; i++) begin
               shadow_in_use[pffs_pkg::PAGE_W'(i)] = 1'b1;
            end
            shadow_depth = present - held;
         end
         pffs_pkg::OP_ALLOC: begin
            if (shadow_depth == 0) begin
               res.status = pffs_pkg::STATUS_EMPTY;
            end else begin
               shadow_depth--;
               res.frame = shadow_stack[pffs_pkg::PAGE_W'(shadow_depth)];
               shadow_in_use[res.frame] = 1'b1;
            end
         end
         pffs_pkg::OP_FREE: begin
            // The range check uses the register as it is now, even if no
            // init has followed a change of the total.
            if (int'(page) >= present) begin
               res.status = pffs_pkg::STATUS_RANGE;
            end else if (!shadow_in_use[page]) begin
               res.status = pffs_pkg::STATUS_NOT_USED;
            end else begin
               shadow_in_use[page] = 1'b0;
               if (shadow_depth < pffs_pkg::MAX_PAGES) begin
                  shadow_stack[pffs_pkg::PAGE_W'(shadow_depth)] = page;
                  shadow_depth++;
               end
               res.frame = page;
            end
         end
         default: begin
         end
      endcase
      res.free_count = pffs_pkg::COUNT_W'(shadow_depth);
      due_results.push_back(res);
   endtask

   // Request driver. A new request is presented only when the previous
   // one has been transferred or none was up, so a stalled request holds.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            allocator_step(req_operation, req_page);
         end
         if (!req_valid || !req_stall) begin
            if (page_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_request = page_requests.pop_front();
               req_valid     <= 1'b1;
               req_operation <= next_request.op;
               req_page      <= next_request.page;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   // Response monitor. The stall is drawn fresh every cycle; every
   // transfer is compared field by field with the oldest expected response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf(
                  "unexpected response frame %0d status %0d free %0d",
                  rsp_frame, rsp_status, rsp_free_count));
            end else begin
               oldest_due = due_results.pop_front();
               if (rsp_frame !== oldest_due.frame || rsp_status !== oldest_due.status ||
                   rsp_free_count !== oldest_due.free_count) begin
                  report_mismatch($sformatf({
                     "response mismatch: expected frame %0d status %0d free %0d, ",
                     "got frame %0d status %0d free %0d"},
                     oldest_due.frame, oldest_due.status, oldest_due.free_count,
                     rsp_frame, rsp_status, rsp_free_count));
               end
            end
         end
      end
   end

   // Queue one request, keeping only a short backlog so that the stimulus
   // can look at the shadow in-use map when it picks frames to free. The
   // idle and stall rates rotate every 97 requests, so every mix of gaps
   // meets every kind of operation, including the long init sweeps.
   task automatic queue_request(input logic [1:0] op,
                                input logic [pffs_pkg::PAGE_W-1:0] page);
      page_request_type item;
      while (page_requests.size() >= 2) begin
         @(negedge clock);
      end
      case ((requests_made / 97) % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
         default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      item.op = op;
      item.page = page;
      page_requests.push_back(item);
      requests_made++;
   endtask

   // Pick a frame that the shadow allocator currently has in use, so most
   // frees succeed and the stack keeps cycling. Falls back to any frame
   // in range when no in-use frame turns up quickly.
   function automatic logic [pffs_pkg::PAGE_W-1:0] pick_used_page();
      int unsigned present;
      int unsigned probe;
      int unsigned k;
      present = frames_present();
      if (present == 0) begin
         return pffs_pkg::PAGE_W'($urandom);
      end
      for (k = 0; k < 16; k++) begin
         probe = $urandom_range(present - 1);
         if (shadow_in_use[pffs_pkg::PAGE_W'(probe)]) begin
            return pffs_pkg::PAGE_W'(probe);
         end
      end
      return pffs_pkg::PAGE_W'($urandom_range(present - 1));
   endfunction

   // Mostly allocs and frees of live frames; a little noise in the form of
   // frees of random 12-bit frame numbers, undefined operations and inits.
   task automatic queue_random_request(input int unsigned alloc_bias);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 1) begin
         queue_request(pffs_pkg::OP_INIT, pffs_pkg::PAGE_W'($urandom));
      end else if (roll < 3) begin
         queue_request(OP_UNDEFINED, pffs_pkg::PAGE_W'($urandom));
      end else if (roll < 9) begin
         queue_request(pffs_pkg::OP_FREE, pffs_pkg::PAGE_W'($urandom));
      end else if ($urandom_range(99) < alloc_bias) begin
         queue_request(pffs_pkg::OP_ALLOC, pffs_pkg::PAGE_W'($urandom));
      end else begin
         queue_request(pffs_pkg::OP_FREE, pick_used_page());
      end
   endtask

   // Registers change only when the block is quiet: nothing queued, no
   // request up and every response back, plus an extra wait that covers
   // the response path.
   task automatic wait_until_quiet();
      do begin
         @(negedge clock);
      end while (page_requests.size() != 0 || req_valid || due_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [pffs_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [pffs_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == pffs_pkg::CSR_TOTAL_PAGES) begin
         shadow_total = value;
      end else begin
         shadow_reserved = value;
      end
   endtask

   // One random phase: new register values, an optional init, then a run
   // of random requests against that setting.
   task automatic run_phase(input logic [pffs_pkg::COUNT_W-1:0] total,
                            input logic [pffs_pkg::COUNT_W-1:0] reserved,
                            input bit rebuild, input int unsigned alloc_bias,
                            input int unsigned count);
      int unsigned n;
      wait_until_quiet();
      write_register(pffs_pkg::CSR_TOTAL_PAGES, total);
      write_register(pffs_pkg::CSR_RESERVED_PAGES, reserved);
      if (rebuild) begin
         queue_request(pffs_pkg::OP_INIT, '0);
      end
      for (n = 0; n < count; n++) begin
         queue_random_request(alloc_bias);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset setting. The stack starts empty and the
      // in-use map clear, so an alloc finds nothing and frees are refused.
      queue_request(pffs_pkg::OP_ALLOC, '0);
      queue_request(pffs_pkg::OP_FREE, '0);
      queue_request(pffs_pkg::OP_FREE, pffs_pkg::LAST_IDX);
      queue_request(OP_UNDEFINED, pffs_pkg::LAST_IDX);

      // A five-frame system with two reserved: three allocs succeed, the
      // fourth finds the stack empty. Frees cover out of range at the top
      // of the page field and just past the total, a reserved frame, a
      // double free and a frame taken by alloc.
      wait_until_quiet();
      write_register(pffs_pkg::CSR_TOTAL_PAGES, pffs_pkg::COUNT_W'(5));
      write_register(pffs_pkg::CSR_RESERVED_PAGES, pffs_pkg::COUNT_W'(2));
      queue_request(pffs_pkg::OP_INIT, pffs_pkg::LAST_IDX);
      queue_request(pffs_pkg::OP_ALLOC, pffs_pkg::LAST_IDX);
      queue_request(pffs_pkg::OP_ALLOC, '0);
      queue_request(pffs_pkg::OP_ALLOC, '0);
      queue_request(pffs_pkg::OP_ALLOC, '0);
      queue_request(pffs_pkg::OP_FREE, pffs_pkg::LAST_IDX);
      queue_request(pffs_pkg::OP_FREE, pffs_pkg::PAGE_W'(5));
      queue_request(pffs_pkg::OP_FREE, '0);
      queue_request(pffs_pkg::OP_FREE, '0);
      queue_request(pffs_pkg::OP_FREE, pffs_pkg::PAGE_W'(4));
      queue_request(pffs_pkg::OP_ALLOC, '0);
      queue_request(OP_UNDEFINED, '0);
      queue_request(pffs_pkg::OP_INIT, '0);

      // Random phases. The first clamps an oversized total and saturates
      // the reserved count, so every frame starts in use. Total zero gives
      // an empty stack where every free is out of range. One phase changes
      // the total without an init, so stacked frames outlive the new range.
      run_phase(pffs_pkg::COUNT_W'(8191), pffs_pkg::COUNT_W'(8191), 1'b1, 50, 250);
      run_phase(pffs_pkg::COUNT_W'(1), pffs_pkg::COUNT_W'(0), 1'b1, 50, 150);
      run_phase(pffs_pkg::COUNT_W'(pffs_pkg::MAX_PAGES), pffs_pkg::COUNT_W'(0),
                1'b1, 60, 300);
      run_phase(pffs_pkg::COUNT_W'(0), pffs_pkg::COUNT_W'(0), 1'b1, 50, 60);
      run_phase(pffs_pkg::COUNT_W'(37), pffs_pkg::COUNT_W'(5), 1'b1, 60, 300);
      run_phase(pffs_pkg::COUNT_W'(20), pffs_pkg::COUNT_W'(3), 1'b0, 50, 250);
      run_phase(pffs_pkg::COUNT_W'(pffs_pkg::MAX_PAGES),
                pffs_pkg::COUNT_W'(pffs_pkg::MAX_PAGES - 1), 1'b1, 40, 300);
      run_phase(pffs_pkg::COUNT_W'(300), pffs_pkg::COUNT_W'(8191), 1'b1, 45, 250);

      wait_until_quiet();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // A correct run spends most of its time in init sweeps; this bound
   // leaves a wide margin.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
sv/pffs_pkg.sv
sv/pffs_ctrl.sv
sv/pffs_dp.sv
sv/page_frame_free_stack_unit.sv
test/tb.sv
